FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lcabl_pkg.sv
// Shared types, constants and helpers of the binary-lifting LCA engine.
package lcabl_pkg;

  // Node ids and depths share one fixed field width.
  localparam int NODE_W = 11;
  localparam logic [NODE_W-1:0] DEPTH_MAX = 11'h7FF;

  // Input command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Request queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Classified operation carried by a queued request.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SKIP,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } req_t;

  // Ids above the node count stand for node zero.
  function automatic logic [NODE_W-1:0] clamp_node(input logic [NODE_W-1:0] v,
                                                   input int unsigned max_nodes);
    return (32'(v) > max_nodes) ? '0 : v;
  endfunction

endpackage

FILE: rtl/lca_binary_lifting_engine_top.sv
// Top level of the binary-lifting lowest-common-ancestor engine.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_stall, cmd, node_a, node_b | request in
//   out     | out_valid, out_stall, result_node, result_depth | result out
//
// A load steps through pop, parent depth, one ancestor read and one write per
// higher level, then the handoff to the output register.
// A query makes up to LEVELS lift reads, then LEVELS joint reads on the
// dual-read ancestor memory if the lifted nodes differ, plus depth lookups.
// Reset clears only control state; memories are undefined until written and
// node zero reads as zero. A two-entry queue buffers requests during stalls.
`include "assert_macros.svh"
module lca_binary_lifting_engine_top import lcabl_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] result_node,
  output logic [NODE_W-1:0] result_depth
);

  logic push;
  logic q_full;
  logic q_valid;
  logic pop;
  req_t entry;
  req_t head;

  lcabl_front #(.MAX_NODES(MAX_NODES)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .node_a   (node_a),
    .node_b   (node_b),
    .q_full   (q_full),
    .push     (push),
    .entry    (entry)
  );

  lcabl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .entry   (entry),
    .full    (q_full),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop)
  );

  lcabl_engine #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (head),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_node  (result_node),
    .result_depth (result_depth)
  );

  // A full queue is never empty.
  `ASSERT_IMPL(a_full_not_empty, q_full, q_valid, "queue full but empty")
  // The engine only pops a request that is there.
  `ASSERT_IMPL(a_pop_valid, pop, q_valid, "pop from empty queue")
  // No result appears in the cycle right after a request is taken.
  `ASSERT_NEXT(a_no_instant_result, pop, !$rose(out_valid), "result too early")

endmodule

FILE: rtl/lcabl_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module lcabl_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1025
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1,
  output logic [WIDTH-1:0]                         rdata0,
  output logic [WIDTH-1:0]                         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered reads (read-old on same-address collision).
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

FILE: rtl/lcabl_front.sv
// Front end: takes input requests, clamps node ids and classifies them.
module lcabl_front import lcabl_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  input  logic              q_full,
  output logic              push,
  output req_t              entry
);

  logic [NODE_W-1:0] a_cl;
  logic [NODE_W-1:0] b_cl;

  assign a_cl = clamp_node(node_a, MAX_NODES);
  assign b_cl = clamp_node(node_b, MAX_NODES);

  // Stall only on a full queue.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Loads of node zero write nothing and answer zero.
  always_comb begin
    entry.a = a_cl;
    entry.b = b_cl;
    unique case (cmd)
      CMD_QUERY: entry.op = OP_QUERY;
      default:   entry.op = (a_cl == '0) ? OP_SKIP : OP_LOAD;
    endcase
  end

endmodule

FILE: rtl/lcabl_queue.sv
// Two-entry request queue between the front end and the engine.
module lcabl_queue import lcabl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t entry,
  output logic full,
  output logic q_valid,
  output req_t head,
  input  logic pop
);

  req_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule

FILE: rtl/lcabl_engine.sv
// Back end: runs loads and queries over the ancestor and depth memories.
module lcabl_engine import lcabl_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  req_t              q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] result_node,
  output logic [NODE_W-1:0] result_depth
);

  localparam int NW        = (MAX_NODES > 1) ? $clog2(MAX_NODES + 1) : 1;
  localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW        = NW + LW;
  localparam int ANC_DEPTH = (MAX_NODES + 1) * (2 ** LW);
  localparam int DEP_DEPTH = MAX_NODES + 1;
  localparam logic [LW-1:0] LAST = LW'(LEVELS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LD_DEP, S_LD_RD, S_LD_WR, S_Q_DEP, S_LIFT, S_LIFT_W,
    S_CMP, S_TOP, S_TOP_W, S_PAR, S_PAR_W, S_RES_DEP, S_RES_W, S_DONE
  } state_t;

  state_t            state;
  logic [NODE_W-1:0] a_r;
  logic [NODE_W-1:0] x;
  logic [NODE_W-1:0] y;
  logic [NODE_W-1:0] diff_sh;
  logic [LW-1:0]     lvl;
  logic [NODE_W-1:0] res_node;
  logic [NODE_W-1:0] res_depth;

  // Memory ports
  logic              anc_we;
  logic [AW-1:0]     anc_waddr;
  logic [NODE_W-1:0] anc_wdata;
  logic [AW-1:0]     anc_raddr0;
  logic [AW-1:0]     anc_raddr1;
  logic [NODE_W-1:0] anc_rdata0;
  logic [NODE_W-1:0] anc_rdata1;
  logic              dep_we;
  logic [NW-1:0]     dep_waddr;
  logic [NODE_W-1:0] dep_wdata;
  logic [NW-1:0]     dep_raddr0;
  logic [NW-1:0]     dep_raddr1;
  logic [NODE_W-1:0] dep_rdata0;
  logic [NODE_W-1:0] dep_rdata1;

  // Read requests: node ids per port, one level shared by both ancestor ports
  logic [NODE_W-1:0] rn_a0;
  logic [NODE_W-1:0] rn_a1;
  logic [LW-1:0]     rl;
  logic [NODE_W-1:0] rn_d0;
  logic [NODE_W-1:0] rn_d1;
  logic              za0, za1, zd0, zd1;

  // Read data with node zero forced to zero
  logic [NODE_W-1:0] av0, av1, dv0, dv1;

  lcabl_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc (
    .clk    (clk),
    .we     (anc_we),
    .waddr  (anc_waddr),
    .wdata  (anc_wdata),
    .raddr0 (anc_raddr0),
    .raddr1 (anc_raddr1),
    .rdata0 (anc_rdata0),
    .rdata1 (anc_rdata1)
  );

  lcabl_ram #(.WIDTH(NODE_W), .DEPTH(DEP_DEPTH)) u_dep (
    .clk    (clk),
    .we     (dep_we),
    .waddr  (dep_waddr),
    .wdata  (dep_wdata),
    .raddr0 (dep_raddr0),
    .raddr1 (dep_raddr1),
    .rdata0 (dep_rdata0),
    .rdata1 (dep_rdata1)
  );

  assign anc_raddr0 = {NW'(rn_a0), rl};
  assign anc_raddr1 = {NW'(rn_a1), rl};
  assign dep_raddr0 = NW'(rn_d0);
  assign dep_raddr1 = NW'(rn_d1);

  assign av0 = za0 ? '0 : clamp_node(anc_rdata0, MAX_NODES);
  assign av1 = za1 ? '0 : clamp_node(anc_rdata1, MAX_NODES);
  assign dv0 = zd0 ? '0 : dep_rdata0;
  assign dv1 = zd1 ? '0 : dep_rdata1;

  assign q_pop = (state == S_IDLE) && q_valid;

  // Zero-node flags follow the registered read data
  always_ff @(posedge clk) begin
    za0 <= (rn_a0 == '0);
    za1 <= (rn_a1 == '0);
    zd0 <= (rn_d0 == '0);
    zd1 <= (rn_d1 == '0);
  end

  // Memory addressing per state
  always_comb begin
    anc_we    = 1'b0;
    anc_waddr = {NW'(a_r), lvl};
    anc_wdata = av0;
    dep_we    = 1'b0;
    dep_waddr = NW'(a_r);
    dep_wdata = (dv0 == DEPTH_MAX) ? dv0 : dv0 + 1'b1;
    rn_a0     = x;
    rn_a1     = y;
    rl        = lvl;
    rn_d0     = res_node;
    rn_d1     = y;
    unique case (state)
      S_IDLE: begin
        rn_d0 = q_head.b;
        rn_d1 = q_head.b;
        if (q_valid && q_head.op == OP_LOAD) begin
          anc_we    = 1'b1;
          anc_waddr = {NW'(q_head.a), LW'(0)};
          anc_wdata = q_head.b;
        end else if (q_valid && q_head.op == OP_QUERY) begin
          rn_d0 = q_head.a;
        end
      end
      S_LD_DEP: dep_we = 1'b1;
      S_LD_RD:  rl = lvl - LW'(1);
      S_LD_WR:  anc_we = 1'b1;
      S_PAR:    rl = '0;
      default: begin
      end
    endcase
  end

  // Sequencer, working registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            a_r <= q_head.a;
            unique case (q_head.op)
              OP_LOAD: begin
                x     <= q_head.b;
                state <= S_LD_DEP;
              end
              OP_QUERY: begin
                x     <= q_head.a;
                y     <= q_head.b;
                state <= S_Q_DEP;
              end
              default: begin
                res_node  <= '0;
                res_depth <= '0;
                state     <= S_DONE;
              end
            endcase
          end
        end
        // Load: depth from parent, then one level per read/write pair
        S_LD_DEP: begin
          res_node  <= a_r;
          res_depth <= dep_wdata;
          lvl       <= LW'(1);
          state     <= (LEVELS > 1) ? S_LD_RD : S_DONE;
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: begin
          x <= av0;
          if (lvl == LAST) begin
            state <= S_DONE;
          end else begin
            lvl   <= lvl + LW'(1);
            state <= S_LD_RD;
          end
        end
        // Query: order by depth and lift the deeper node
        S_Q_DEP: begin
          if (dv0 < dv1) begin
            x       <= y;
            y       <= x;
            diff_sh <= dv1 - dv0;
          end else begin
            diff_sh <= dv0 - dv1;
          end
          lvl   <= '0;
          state <= S_LIFT;
        end
        S_LIFT: begin
          if (diff_sh[0]) begin
            state <= S_LIFT_W;
          end else begin
            diff_sh <= diff_sh >> 1;
            if (lvl == LAST) state <= S_CMP;
            else lvl <= lvl + LW'(1);
          end
        end
        S_LIFT_W: begin
          x       <= av0;
          diff_sh <= diff_sh >> 1;
          if (lvl == LAST) begin
            state <= S_CMP;
          end else begin
            lvl   <= lvl + LW'(1);
            state <= S_LIFT;
          end
        end
        S_CMP: begin
          if (x == y) begin
            res_node <= x;
            state    <= S_RES_DEP;
          end else begin
            lvl   <= LAST;
            state <= S_TOP;
          end
        end
        // Joint lift from the top level down
        S_TOP: state <= S_TOP_W;
        S_TOP_W: begin
          if (av0 != av1) begin
            x <= av0;
            y <= av1;
          end
          if (lvl == '0) begin
            state <= S_PAR;
          end else begin
            lvl   <= lvl - LW'(1);
            state <= S_TOP;
          end
        end
        S_PAR: state <= S_PAR_W;
        S_PAR_W: begin
          res_node <= av0;
          state    <= S_RES_DEP;
        end
        S_RES_DEP: state <= S_RES_W;
        S_RES_W: begin
          res_depth <= dv0;
          state     <= S_DONE;
        end
        // Hand the result to the output register once it is free
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            result_node  <= res_node;
            result_depth <= res_depth;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
